// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RLE palette tile decoder RTL.
// No dependencies; every macro samples on clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Signal must never be high outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== sv/rptd_pkg.sv =====
// Package for the RLE palette tile decoder: phases, status codes, job and
// response-item types, and the packed-index helper. No dependencies.
package rptd_pkg;

   localparam int DEF_MAX_TILE_SIDE = 64;
   localparam int DEF_PALETTE_DEPTH = 128;

   localparam int RUN_W   = 13;
   localparam int IX_W    = 7;
   localparam int COLOR_W = 16;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_TRUNC = 2'd1;
   localparam logic [1:0] ST_BADIX = 2'd2;
   localparam logic [1:0] ST_UNSUP = 2'd3;

   localparam logic [7:0] SUB_RAW   = 8'd0;
   localparam logic [7:0] SUB_SOLID = 8'd1;
   localparam logic [7:0] SUB_PK_LO = 8'd2;
   localparam logic [7:0] SUB_PK_2B = 8'd4;
   localparam logic [7:0] SUB_PK_HI = 8'd16;
   localparam logic [7:0] SUB_RLE   = 8'd128;
   localparam logic [7:0] SUB_PRLE  = 8'd130;
   localparam logic [7:0] RUN_MORE  = 8'hFF;

   // index width of a packed byte
   localparam logic [1:0] BSEL_1 = 2'd0;
   localparam logic [1:0] BSEL_2 = 2'd1;
   localparam logic [1:0] BSEL_4 = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PAL_LO,
      PH_PAL_HI,
      PH_PIX_LO,
      PH_PIX_HI,
      PH_RUN,
      PH_INDEX
   } phase_type;

   // Work left behind by one request: runs first, then up to two errors.
   typedef struct packed {
      logic [3:0]         n_runs;
      logic [1:0]         n_err;
      logic [1:0]         err0;
      logic [1:0]         err1;
      logic               last_done;
      logic               pal;
      logic               pk;
      logic [1:0]         bsel;
      logic [7:0]         pk_byte;
      logic [IX_W-1:0]    ix;
      logic [COLOR_W-1:0] color;
      logic [RUN_W-1:0]   run;
   } job_type;

   // One response waiting on the palette read.
   typedef struct packed {
      logic               is_run;
      logic               use_pal;
      logic [COLOR_W-1:0] color;
      logic [RUN_W-1:0]   run;
      logic               done;
      logic [1:0]         status;
   } item_type;

   function automatic logic [3:0] pk_index(input logic [7:0] v, input logic [1:0] bsel,
                                           input logic [2:0] pos);
      logic [7:0] sh;
      logic [3:0] ix;
      case (bsel)
         BSEL_1: begin
            sh = v << pos;
            ix = {3'b000, sh[7]};
         end
         BSEL_2: begin
            sh = v << {pos, 1'b0};
            ix = {2'b00, sh[7:6]};
         end
         default: begin
            sh = v << {pos, 2'b00};
            ix = sh[7:4];
         end
      endcase
      return ix;
   endfunction

   function automatic logic [31:0] to_argb(input logic [COLOR_W-1:0] v);
      return {8'hFF, v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
   endfunction

endpackage

// ===== sv/rptd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read-first when both ports hit the same entry.
module rptd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/rle_palette_tile_decoder.sv =====
// Decoder for one inflated RLE tile: one request per payload byte, colour runs out as ARGB.
// Depends on rptd_pkg, rptd_ram and assert_macros.svh.
//
// A request that yields at most one response is taken every cycle unless the output stalls.
// A request that yields several responses (a packed-index byte gives up to eight
// single-pixel runs, a tile start up to two error responses) holds the input until its
// last response is issued: responses leave a job register one per cycle while the output
// is not stalled, through the single palette read port, then a read stage and an output
// register. The palette memory is not cleared; an entry never loaded reads as garbage. Runs
// of a tile that ends with a nonzero status must be discarded downstream.
module rle_palette_tile_decoder
   import rptd_pkg::*;
#(
   parameter int MAX_TILE_SIDE = DEF_MAX_TILE_SIDE,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_tile_start,
   input  logic        req_tile_end,
   input  logic [6:0]  req_tile_width,
   input  logic [6:0]  req_tile_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_argb_color,
   output logic [12:0] rsp_run_pixels,
   output logic        rsp_tile_done,
   output logic [1:0]  rsp_status
);

`include "assert_macros.svh"

   localparam int SIDE_CAP = (MAX_TILE_SIDE < 127) ? MAX_TILE_SIDE : 127;
   localparam int SIDE_W   = $clog2(SIDE_CAP + 1);
   localparam int LEFT_W   = $clog2(SIDE_CAP * SIDE_CAP + 1);
   localparam int PAL_AW   = $clog2(PALETTE_DEPTH);

   // decode state
   phase_type          phase_ff, phase_in;
   logic [7:0]         sub_ff, sub_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [IX_W-1:0]    loaded_ff, loaded_in;
   logic [7:0]         lo_ff, lo_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [IX_W-1:0]    cix_ff, cix_in;
   logic               cpal_ff, cpal_in;
   logic [LEFT_W-1:0]  acc_ff, acc_in;

   logic               req_fire;
   logic [SIDE_W-1:0]  w_side, h_side;
   logic [2*SIDE_W-1:0] tile_prod;
   logic [7:0]         pal_size;
   logic [IX_W-1:0]    loaded_inc;
   logic [LEFT_W:0]    run_sum;
   logic [LEFT_W-1:0]  acc_new;
   logic [1:0]         bsel;
   logic [3:0]         pk_cnt, pk_take;
   logic [3:0]         pk_ix;
   logic               bad_found;
   logic [2:0]         bad_pos;
   logic               do_paint;
   logic [LEFT_W-1:0]  paint_run;
   logic [LEFT_W-1:0]  paint_left;
   logic               pal_we;
   logic [COLOR_W-1:0] new_color;
   job_type            jb;
   logic [3:0]         jb_total;

   // emission pipeline
   logic               job_valid_ff;
   job_type            job_ff;
   logic [2:0]         step_ff;
   logic               issue, o_adv, step_last;
   item_type           item, s1_ff;
   logic               s1_valid_ff;
   logic [3:0]         step_ext;
   logic [COLOR_W-1:0] ram_rd;
   logic [IX_W-1:0]    rd_ix;
   logic [31:0]        o_argb_ff;
   logic [RUN_W-1:0]   o_run_ff;
   logic               o_done_ff;
   logic [1:0]         o_status_ff;
   logic               o_valid_ff;

   assign req_fire = req_valid && req_ready;

   always_comb begin
      w_side = (req_tile_width == 7'd0) ? SIDE_W'(1) :
               (32'(req_tile_width) > SIDE_CAP) ? SIDE_W'(SIDE_CAP) : SIDE_W'(req_tile_width);
      h_side = (req_tile_height == 7'd0) ? SIDE_W'(1) :
               (32'(req_tile_height) > SIDE_CAP) ? SIDE_W'(SIDE_CAP) : SIDE_W'(req_tile_height);
      tile_prod = (2*SIDE_W)'(w_side) * (2*SIDE_W)'(h_side);
   end

   assign pal_size   = (sub_ff >= SUB_PRLE) ? (sub_ff - SUB_RLE) : sub_ff;
   assign loaded_inc = loaded_ff + IX_W'(1);
   assign new_color  = {req_data_byte, lo_ff};
   assign run_sum    = {1'b0, acc_ff} + (LEFT_W+1)'(req_data_byte);
   assign acc_new    = (run_sum > {1'b0, left_ff}) ? left_ff : run_sum[LEFT_W-1:0];

   // packed index scan: how many indices fit, and the first bad one among them
   always_comb begin
      bsel   = (sub_ff == SUB_PK_LO) ? BSEL_1 : (sub_ff <= SUB_PK_2B) ? BSEL_2 : BSEL_4;
      pk_cnt = (bsel == BSEL_1) ? 4'd8 : (bsel == BSEL_2) ? 4'd4 : 4'd2;
      pk_take = (left_ff < LEFT_W'(pk_cnt)) ? left_ff[3:0] : pk_cnt;
      bad_found = 1'b0;
      bad_pos   = 3'd0;
      pk_ix     = 4'd0;
      for (int i = 0; i < 8; i++) begin
         pk_ix = pk_index(req_data_byte, bsel, 3'(i));
         if (!bad_found && (4'(i) < pk_take) && ({4'b0000, pk_ix} >= sub_ff)) begin
            bad_found = 1'b1;
            bad_pos   = 3'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sub_ff    <= '0;
         left_ff   <= '0;
         loaded_ff <= '0;
         lo_ff     <= '0;
         color_ff  <= '0;
         cix_ff    <= '0;
         cpal_ff   <= 1'b0;
         acc_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         sub_ff    <= sub_in;
         left_ff   <= left_in;
         loaded_ff <= loaded_in;
         lo_ff     <= lo_in;
         color_ff  <= color_in;
         cix_ff    <= cix_in;
         cpal_ff   <= cpal_in;
         acc_ff    <= acc_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      sub_in    = sub_ff;
      left_in   = left_ff;
      loaded_in = loaded_ff;
      lo_in     = lo_ff;
      color_in  = color_ff;
      cix_in    = cix_ff;
      cpal_in   = cpal_ff;
      acc_in    = acc_ff;
      jb        = '0;
      pal_we    = 1'b0;
      do_paint  = 1'b0;
      paint_run = '0;
      paint_left = '0;
      if (req_fire) begin
         if (req_tile_start) begin
            if (phase_ff != PH_IDLE) begin
               jb.n_err = 2'd1;
               jb.err0  = ST_TRUNC;
            end
            sub_in    = req_data_byte;
            left_in   = tile_prod[LEFT_W-1:0];
            loaded_in = '0;
            acc_in    = '0;
            if (req_data_byte == SUB_RAW || req_data_byte == SUB_SOLID ||
                req_data_byte == SUB_RLE) begin
               phase_in = PH_PIX_LO;
            end else if ((req_data_byte >= SUB_PK_LO && req_data_byte <= SUB_PK_HI) ||
                         req_data_byte >= SUB_PRLE) begin
               phase_in = PH_PAL_LO;
            end else begin
               phase_in = PH_IDLE;
               if (jb.n_err == 2'd0) begin
                  jb.err0 = ST_UNSUP;
               end else begin
                  jb.err1 = ST_UNSUP;
               end
               jb.n_err = jb.n_err + 2'd1;
            end
            if (req_tile_end && phase_in != PH_IDLE) begin
               phase_in = PH_IDLE;
               if (jb.n_err == 2'd0) begin
                  jb.err0 = ST_TRUNC;
               end else begin
                  jb.err1 = ST_TRUNC;
               end
               jb.n_err = jb.n_err + 2'd1;
            end
         end else if (phase_ff != PH_IDLE) begin
            unique case (phase_ff)
               PH_PAL_LO, PH_PIX_LO: begin
                  lo_in    = req_data_byte;
                  phase_in = (phase_ff == PH_PAL_LO) ? PH_PAL_HI : PH_PIX_HI;
               end
               PH_PAL_HI: begin
                  pal_we    = 1'b1;
                  loaded_in = loaded_inc;
                  phase_in  = ({1'b0, loaded_inc} >= pal_size) ? PH_INDEX : PH_PAL_LO;
               end
               PH_PIX_HI: begin
                  if (sub_ff == SUB_RAW) begin
                     phase_in  = PH_PIX_LO;
                     do_paint  = 1'b1;
                     paint_run = LEFT_W'(1);
                     jb.color  = new_color;
                  end else if (sub_ff == SUB_SOLID) begin
                     do_paint  = 1'b1;
                     paint_run = left_ff;
                     jb.color  = new_color;
                  end else begin
                     color_in = new_color;
                     cpal_in  = 1'b0;
                     acc_in   = LEFT_W'(1);
                     phase_in = PH_RUN;
                  end
               end
               PH_RUN: begin
                  acc_in = acc_new;
                  if (req_data_byte != RUN_MORE) begin
                     phase_in  = (sub_ff == SUB_RLE) ? PH_PIX_LO : PH_INDEX;
                     do_paint  = 1'b1;
                     paint_run = acc_new;
                     jb.pal    = cpal_ff;
                     jb.ix     = cix_ff;
                     jb.color  = color_ff;
                  end
               end
               PH_INDEX: begin
                  if (sub_ff <= SUB_PK_HI) begin
                     jb.pk      = 1'b1;
                     jb.bsel    = bsel;
                     jb.pk_byte = req_data_byte;
                     jb.run     = RUN_W'(1);
                     if (bad_found) begin
                        jb.n_runs = {1'b0, bad_pos};
                        left_in   = left_ff - LEFT_W'(bad_pos);
                        jb.n_err  = 2'd1;
                        jb.err0   = ST_BADIX;
                        phase_in  = PH_IDLE;
                     end else begin
                        jb.n_runs = pk_take;
                        left_in   = left_ff - LEFT_W'(pk_take);
                        jb.last_done = (left_in == '0);
                        if (jb.last_done) begin
                           phase_in = PH_IDLE;
                        end
                     end
                  end else if ({1'b0, req_data_byte[6:0]} >= pal_size) begin
                     jb.n_err = 2'd1;
                     jb.err0  = ST_BADIX;
                     phase_in = PH_IDLE;
                  end else if (req_data_byte[7]) begin
                     cix_in   = req_data_byte[6:0];
                     cpal_in  = 1'b1;
                     acc_in   = LEFT_W'(1);
                     phase_in = PH_RUN;
                  end else begin
                     do_paint  = 1'b1;
                     paint_run = LEFT_W'(1);
                     jb.pal    = 1'b1;
                     jb.ix     = req_data_byte[6:0];
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            // single run, never longer than what is left of the tile
            if (do_paint) begin
               paint_left   = left_ff - paint_run;
               left_in      = paint_left;
               jb.n_runs    = 4'd1;
               jb.run       = RUN_W'(paint_run);
               jb.last_done = (paint_left == '0);
               if (jb.last_done) begin
                  phase_in = PH_IDLE;
               end
            end
            // incomplete at tile end: drop the runs, report truncation
            if (req_tile_end && phase_in != PH_IDLE) begin
               jb       = '0;
               jb.n_err = 2'd1;
               jb.err0  = ST_TRUNC;
               phase_in = PH_IDLE;
            end
         end
      end
   end

   assign jb_total = jb.n_runs + {2'b00, jb.n_err};

   // emission: one response per cycle out of the job register while the output is not stalled
   assign o_adv     = !o_valid_ff || rsp_ready;
   assign issue     = job_valid_ff && (!s1_valid_ff || o_adv);
   assign step_ext  = {1'b0, step_ff};
   assign step_last = (step_ext == (job_ff.n_runs + {2'b00, job_ff.n_err} - 4'd1));
   assign req_ready = !job_valid_ff || (issue && step_last);

   always_comb begin
      item  = '0;
      rd_ix = job_ff.ix;
      if (step_ext < job_ff.n_runs) begin
         item.is_run  = 1'b1;
         item.use_pal = job_ff.pal || job_ff.pk;
         item.color   = job_ff.color;
         item.run     = job_ff.run;
         item.done    = job_ff.last_done && (step_ext == job_ff.n_runs - 4'd1);
         item.status  = ST_RUN;
         if (job_ff.pk) begin
            rd_ix = IX_W'(pk_index(job_ff.pk_byte, job_ff.bsel, step_ff));
         end
      end else begin
         item.done   = 1'b1;
         item.status = (step_ext == job_ff.n_runs) ? job_ff.err0 : job_ff.err1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         if (req_fire && jb_total != 4'd0) begin
            job_valid_ff <= 1'b1;
            step_ff      <= '0;
         end else if (issue) begin
            if (step_last) begin
               job_valid_ff <= 1'b0;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (o_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (o_adv) begin
            o_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         job_ff <= jb;
      end
      if (issue) begin
         s1_ff <= item;
      end
      if (o_adv && s1_valid_ff) begin
         o_argb_ff   <= s1_ff.is_run ? to_argb(s1_ff.use_pal ? ram_rd : s1_ff.color) : 32'd0;
         o_run_ff    <= s1_ff.run;
         o_done_ff   <= s1_ff.done;
         o_status_ff <= s1_ff.status;
      end
   end

   rptd_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(PAL_AW'(loaded_ff)),
      .wr_data(new_color),
      .rd_en  (issue),
      .rd_addr(PAL_AW'(rd_ix)),
      .rd_data(ram_rd)
   );

   assign rsp_valid      = o_valid_ff;
   assign rsp_argb_color = o_argb_ff;
   assign rsp_run_pixels = o_run_ff;
   assign rsp_tile_done  = o_done_ff;
   assign rsp_status     = o_status_ff;

   `ASSERT_CLK(a_req_only_when_job_drains, req_fire |-> (!job_valid_ff || (issue && step_last)), "request taken over a pending job")
   `ASSERT_CLK(a_err_closes_tile, (rsp_valid && (rsp_status != ST_RUN)) |-> (rsp_tile_done && (rsp_run_pixels == '0) && (rsp_argb_color == '0)), "error response malformed")
   `ASSERT_NEVER(a_run_nonempty, rsp_valid && (rsp_status == ST_RUN) && (rsp_run_pixels == '0), "empty run emitted")

endmodule
